// ===== src/wacl_pkg.sv =====
// shared types and constants for the wildcard acl packet filter
// used by the digit cells and the top level; depends on nothing
`default_nettype none

package wacl_pkg;

	localparam int DIGIT_W    = 4;
	localparam int ADDR_W     = 32;
	localparam int MASK_W     = 8;
	localparam int NUM_DIGITS = ADDR_W / DIGIT_W;
	localparam int OUT_IDX_W  = 10;
	localparam int S_TDATA_W  = 88;
	localparam int M_TDATA_W  = 16;

	typedef enum logic [1:0] {
		REQ_CLEAR    = 2'd0,
		REQ_APPEND   = 2'd1,
		REQ_CLASSIFY = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              action;
		logic [ADDR_W-1:0] src_val;
		logic [MASK_W-1:0] src_mask;
		logic [ADDR_W-1:0] dst_val;
		logic [MASK_W-1:0] dst_mask;
	} rule_t;

	localparam int RULE_W = $bits(rule_t);

	// control that travels along the cell chain with each rule
	typedef struct packed {
		logic valid;
		logic last;
		logic match;
	} ctl_t;

endpackage

`default_nettype wire

// ===== src/wildcard_acl_packet_filter.sv =====
// Wildcard ACL packet filter. Each input beat clears the rule table, appends a
// rule, or classifies a packet; only a classify returns a result beat. Clear
// and append leave the filter idle. A classify reads the stored rules out of
// the rule memory one per cycle and streams them through a chain of digit
// cells, one cell per compared digit. When the output register is free, the
// result register is loaded once the last rule has passed the ram read and
// issue registers, the cell chain and the decision register (straight after
// the classify beat on an empty table), and the next input beat is taken in
// the cycle after the load. The last matching rule decides, and a packet no
// rule matches is denied. Clear and append beats are taken while an earlier
// result still waits in the output register. No clearing pass is needed after
// reset.
// depends on wacl_pkg, wacl_ram, wacl_cell
`default_nettype none

module wildcard_acl_packet_filter #(
	parameter int MAX_RULES   = 1024,
	parameter int ADDR_DIGITS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// permit[0], src_digits[32:1], src_wild[40:33], dst_digits[72:41],
	// dst_wild[80:73], zero[87:81]
	input  wire logic [wacl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// req_type[1:0]
	input  wire logic [1:0]                      s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// allowed[0], any_match[1], deciding_rule[11:2], zero[15:12]
	output logic      [wacl_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

	localparam int AW    = MAX_RULES > 1 ? $clog2(MAX_RULES) : 1;
	localparam int CNT_W = $clog2(MAX_RULES + 1);
	localparam int NC    = ADDR_DIGITS < wacl_pkg::NUM_DIGITS ? ADDR_DIGITS
		: wacl_pkg::NUM_DIGITS;

	wacl_pkg::state_t state_q, state_d;
	wacl_pkg::req_t   req;
	logic             s_fire;
	logic             scan_re;
	logic             scan_last;
	logic             fin_load;

	logic              in_permit;
	logic [31:0]       in_src;
	logic [7:0]        in_src_wild;
	logic [31:0]       in_dst;
	logic [7:0]        in_dst_wild;

	logic [CNT_W-1:0]  held_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              ram_we;
	wacl_pkg::rule_t   wr_rule;
	logic [wacl_pkg::RULE_W-1:0] ram_rdata;

	wacl_pkg::ctl_t    iss_ctl_s1;
	logic [AW-1:0]     iss_idx_s1;

	wacl_pkg::ctl_t    chain_ctl  [0:NC];
	logic [AW-1:0]     chain_idx  [0:NC];
	wacl_pkg::rule_t   chain_rule [0:NC];

	logic              allowed_q;
	logic              matched_q;
	logic [AW-1:0]     last_q;
	logic [31:0]       last_ext;

	logic              out_valid_q;
	logic              out_allowed_q;
	logic              out_match_q;
	logic [wacl_pkg::OUT_IDX_W-1:0] out_rule_q;

	assign req         = wacl_pkg::req_t'(s_axis_tuser);
	assign s_fire      = s_axis_tvalid && s_axis_tready;
	assign in_permit   = s_axis_tdata[0];
	assign in_src      = s_axis_tdata[32:1];
	assign in_src_wild = s_axis_tdata[40:33];
	assign in_dst      = s_axis_tdata[72:41];
	assign in_dst_wild = s_axis_tdata[80:73];

	assign scan_last = (rd_cnt_q == held_q - CNT_W'(1));

	// control fsm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wacl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		scan_re       = 1'b0;
		fin_load      = 1'b0;
		unique case (state_q)
			wacl_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && req == wacl_pkg::REQ_CLASSIFY) begin
					state_d = (held_q == '0) ? wacl_pkg::ST_FINISH : wacl_pkg::ST_SCAN;
				end
			end
			wacl_pkg::ST_SCAN: begin
				scan_re = 1'b1;
				if (scan_last) begin
					state_d = wacl_pkg::ST_DRAIN;
				end
			end
			wacl_pkg::ST_DRAIN: begin
				if (chain_ctl[NC].valid && chain_ctl[NC].last) begin
					state_d = wacl_pkg::ST_FINISH;
				end
			end
			wacl_pkg::ST_FINISH: begin
				if (!out_valid_q || m_axis_tready) begin
					fin_load = 1'b1;
					state_d  = wacl_pkg::ST_IDLE;
				end
			end
			default: state_d = wacl_pkg::ST_IDLE;
		endcase
	end

	// table fill count and scan counter
	assign ram_we = s_fire && req == wacl_pkg::REQ_APPEND && held_q < CNT_W'(MAX_RULES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			rd_cnt_q <= '0;
		end else begin
			if (s_fire) begin
				unique case (req)
					wacl_pkg::REQ_CLEAR:    held_q <= '0;
					wacl_pkg::REQ_APPEND:   if (ram_we) held_q <= held_q + CNT_W'(1);
					wacl_pkg::REQ_CLASSIFY: rd_cnt_q <= '0;
					default: ;
				endcase
			end
			if (scan_re) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		wr_rule.action   = in_permit;
		wr_rule.src_val  = in_src;
		wr_rule.src_mask = in_src_wild;
		wr_rule.dst_val  = in_dst;
		wr_rule.dst_mask = in_dst_wild;
	end

	wacl_ram #(
		.WIDTH (wacl_pkg::RULE_W),
		.DEPTH (MAX_RULES)
	) u_rules (
		.clk   (clk),
		.we    (ram_we),
		.waddr (held_q[AW-1:0]),
		.wdata (wr_rule),
		.re    (scan_re),
		.raddr (rd_cnt_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// issue stage lines up with the registered ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_ctl_s1 <= '0;
		end else begin
			iss_ctl_s1.valid <= scan_re;
			iss_ctl_s1.last  <= scan_re && scan_last;
			iss_ctl_s1.match <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		iss_idx_s1 <= rd_cnt_q[AW-1:0];
	end

	assign chain_ctl[0]  = iss_ctl_s1;
	assign chain_idx[0]  = iss_idx_s1;
	assign chain_rule[0] = wacl_pkg::rule_t'(ram_rdata);

	for (genvar k = 0; k < NC; k++) begin : g_cell
		wacl_cell #(
			.IDX_W (AW),
			.DIGIT (k)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.load          (s_fire),
			.pkt_src_digit (in_src[k*wacl_pkg::DIGIT_W +: wacl_pkg::DIGIT_W]),
			.pkt_src_wild  (in_src_wild[k]),
			.pkt_dst_digit (in_dst[k*wacl_pkg::DIGIT_W +: wacl_pkg::DIGIT_W]),
			.pkt_dst_wild  (in_dst_wild[k]),
			.in_ctl        (chain_ctl[k]),
			.in_idx        (chain_idx[k]),
			.in_rule       (chain_rule[k]),
			.out_ctl       (chain_ctl[k+1]),
			.out_idx       (chain_idx[k+1]),
			.out_rule      (chain_rule[k+1])
		);
	end

	// later matches overwrite earlier ones, so the last match wins
	always_ff @(posedge clk) begin
		if (s_fire) begin
			allowed_q <= 1'b0;
			matched_q <= 1'b0;
			last_q    <= '0;
		end else if (chain_ctl[NC].valid && chain_ctl[NC].match) begin
			allowed_q <= chain_rule[NC].action;
			matched_q <= 1'b1;
			last_q    <= chain_idx[NC];
		end
	end

	assign last_ext = 32'(last_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_allowed_q <= allowed_q;
			out_match_q   <= matched_q;
			out_rule_q    <= last_ext[wacl_pkg::OUT_IDX_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_rule_q, out_match_q, out_allowed_q};

`ifndef NO_ASSERTIONS
	a_chain_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain_ctl[NC].valid |-> (state_q == wacl_pkg::ST_SCAN ||
		state_q == wacl_pkg::ST_DRAIN))
		else $error("rule beat left the cell chain outside a scan");

	a_idle_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wacl_pkg::ST_IDLE |-> !iss_ctl_s1.valid && !chain_ctl[NC].valid)
		else $error("cell chain not empty while idle");

	a_full_append_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && req == wacl_pkg::REQ_APPEND && held_q == CNT_W'(MAX_RULES))
		|=> $stable(held_q))
		else $error("append to a full table changed the fill count");

	a_held_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> held_q < CNT_W'(MAX_RULES))
		else $error("rule written beyond table capacity");

	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wacl_pkg::ST_FINISH && out_valid_q && !m_axis_tready)
		|=> state_q == wacl_pkg::ST_FINISH)
		else $error("result overwrote a beat still waiting");
`endif

endmodule

`default_nettype wire

// ===== src/wacl_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module wacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/wacl_cell.sv =====
// one digit cell of the match chain: holds one packet digit of each address
// and folds its compare into the match flag of the passing rule; uses wacl_pkg
`default_nettype none

module wacl_cell #(
	parameter int IDX_W = 10,
	parameter int DIGIT = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic [wacl_pkg::DIGIT_W-1:0]  pkt_src_digit,
	input  wire logic                          pkt_src_wild,
	input  wire logic [wacl_pkg::DIGIT_W-1:0]  pkt_dst_digit,
	input  wire logic                          pkt_dst_wild,
	input  wire wacl_pkg::ctl_t                in_ctl,
	input  wire logic [IDX_W-1:0]              in_idx,
	input  wire wacl_pkg::rule_t               in_rule,
	output wacl_pkg::ctl_t                     out_ctl,
	output logic      [IDX_W-1:0]              out_idx,
	output wacl_pkg::rule_t                    out_rule
);

	logic [wacl_pkg::DIGIT_W-1:0] src_dig_q;
	logic                         src_wild_q;
	logic [wacl_pkg::DIGIT_W-1:0] dst_dig_q;
	logic                         dst_wild_q;
	wacl_pkg::ctl_t               ctl_q;
	logic [IDX_W-1:0]             idx_q;
	wacl_pkg::rule_t              rule_q;
	logic                         src_ok;
	logic                         dst_ok;

	// a wildcard on either side makes the digit match
	assign src_ok = src_wild_q || in_rule.src_mask[DIGIT] ||
		(src_dig_q == in_rule.src_val[DIGIT*wacl_pkg::DIGIT_W +: wacl_pkg::DIGIT_W]);
	assign dst_ok = dst_wild_q || in_rule.dst_mask[DIGIT] ||
		(dst_dig_q == in_rule.dst_val[DIGIT*wacl_pkg::DIGIT_W +: wacl_pkg::DIGIT_W]);

	always_ff @(posedge clk) begin
		if (load) begin
			src_dig_q  <= pkt_src_digit;
			src_wild_q <= pkt_src_wild;
			dst_dig_q  <= pkt_dst_digit;
			dst_wild_q <= pkt_dst_wild;
		end
		idx_q  <= in_idx;
		rule_q <= in_rule;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.valid <= in_ctl.valid;
			ctl_q.last  <= in_ctl.last;
			ctl_q.match <= in_ctl.match && src_ok && dst_ok;
		end
	end

	assign out_ctl  = ctl_q;
	assign out_idx  = idx_q;
	assign out_rule = rule_q;

endmodule

`default_nettype wire
